// ----- src/cops_pkg.sv -----
// Package for the circular orbit position step block.
// Holds payload structs and register index codes; no dependencies.
`timescale 1ns / 1ps
package cops_pkg;

  typedef struct packed {
    logic [31:0]        tick;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } cops_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        spin_angle;
    logic               spin_valid;
  } cops_out_t;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_RADIUS = 3'd1;
  localparam logic [2:0] REG_PHASE  = 3'd2;
  localparam logic [2:0] REG_ORATE  = 3'd3;
  localparam logic [2:0] REG_SRATE  = 3'd4;
  localparam logic [2:0] REG_BASE   = 3'd5;

endpackage

// ----- src/cops_serial_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle, for the orbit block.
// Unsigned A x B; the multiplier operand B is W bits wide. No package use.
`timescale 1ns / 1ps
module cops_serial_mul #(
  parameter int AW = 32,
  parameter int W  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [AW-1:0]     a,
  input  logic [W-1:0]      b,
  output logic              done,
  output logic [AW+W-1:0]   prod
);
  localparam int CW = $clog2(W + 1);

  logic [AW-1:0]   mcand;
  logic [W-1:0]    mplier;
  logic [AW+W-1:0] acc;
  logic [CW-1:0]   cnt;
  logic            busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        mcand  <= a;
        mplier <= b;
        acc    <= '0;
        cnt    <= CW'(W);
      end else if (busy) begin
        // acc holds partial sum aligned to the top; shift right each bit
        acc <= {1'b0, acc[AW+W-1:1]} +
               (mplier[0] ? {1'b0, mcand, {(W-1){1'b0}}} : '0);
        mplier <= mplier >> 1;
        cnt    <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;
endmodule

// ----- src/circular_orbit_position_step.sv -----
// Circular orbit position step: polynomial sine/cosine, radius scaling, velocity.
// Uses cops_pkg and one shared shift-add multiplier cops_serial_mul.
// Twelve products run one after another on the one serial multiplier, 32 multiplier bits
// each. A new transaction is accepted only after the last result is taken; in_ready only when idle.
// Synchronous active-high reset clears config registers, previous position and control.
`timescale 1ns / 1ps
module circular_orbit_position_step #(
  parameter int TICKS_PER_SECOND = 16,
  parameter int SINE_BITS        = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cops_pkg::cops_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cops_pkg::cops_out_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import cops_pkg::*;

  localparam int F   = SINE_BITS - 1;
  localparam int SH  = 30 - F;
  localparam longint A_Q30 = 64'd1686629713;
  localparam longint C_Q30 = 64'd76016977;
  localparam longint CA = (A_Q30 + (64'd1 << (SH - 1))) >> SH;
  localparam longint CC = (C_Q30 + (64'd1 << (SH - 1))) >> SH;
  localparam longint CB = CA + CC - (64'd1 << F);
  localparam int MW = 32; // multiplier operand width
  localparam int SW = F + 2;

  typedef enum logic [4:0] {
    S_IDLE, S_ELAP, S_PH, S_SPIN, S_SEL,
    S_U2, S_T1, S_T2, S_S, S_OFF, S_POS, S_VEL, S_OUT
  } state_t;

  state_t state;
  logic        en;
  logic [31:0] radius, sphase, orate, srate, base;
  cops_in_t    item;
  logic [31:0] elapsed, phase, spin;
  logic        axis;        // 0: x (sine), 1: z (cosine)
  logic [F:0]  u, u2;
  logic        sneg;
  logic signed [33:0] offx, offz;
  logic signed [31:0] px, pz;
  logic signed [31:0] prev_x, prev_y, prev_z;
  logic        prev_known;
  logic [1:0]  vidx;
  cops_out_t   res;

  logic            m_start, m_done;
  logic [31:0]     m_a, m_b;
  logic [63:0]     m_p;

  cops_serial_mul #(.AW(32), .W(MW)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b),
    .done(m_done), .prod(m_p)
  );

  logic [31:0] qphase;
  logic [F:0]  uraw;
  assign qphase = phase + (axis ? 32'h4000_0000 : 32'd0);
  assign uraw   = (F+1)'(qphase[29:0] >> SH);

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic signed [47:0] vdiff;
  logic signed [31:0] vcur, vprev;
  always_comb begin
    unique case (vidx)
      2'd0:    begin vcur = px;          vprev = prev_x; end
      2'd1:    begin vcur = item.center_y; vprev = prev_y; end
      default: begin vcur = pz;          vprev = prev_z; end
    endcase
    vdiff = (48'(vcur) - 48'(vprev)) * 48'(TICKS_PER_SECOND);
  end

  logic [F+1:0] t1w;
  assign t1w = (F+2)'(CB) - (F+2)'(m_p[F+SW+31:F] & {(F+2){1'b1}});

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      en <= 1'b0; radius <= '0; sphase <= '0; orate <= '0; srate <= '0; base <= '0;
      prev_x <= '0; prev_y <= '0; prev_z <= '0; prev_known <= 1'b0;
      m_start <= 1'b0;
    end else begin
      m_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE: en     <= cfg_data[0];
          REG_RADIUS: radius <= cfg_data;
          REG_PHASE:  sphase <= cfg_data;
          REG_ORATE:  orate  <= cfg_data;
          REG_SRATE:  srate  <= cfg_data;
          REG_BASE:   base   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid && en) begin
          item <= in_data;
          elapsed <= in_data.tick - base;
          state <= S_ELAP;
        end
        S_ELAP: begin
          m_a <= orate; m_b <= elapsed; m_start <= 1'b1; state <= S_PH;
        end
        S_PH: if (m_done) begin
          phase <= sphase + m_p[31:0];
          m_a <= srate; m_b <= elapsed; m_start <= 1'b1; state <= S_SPIN;
        end
        S_SPIN: if (m_done) begin
          spin <= m_p[31:0]; axis <= 1'b0; state <= S_SEL;
        end
        S_SEL: begin
          u    <= qphase[30] ? (F+1)'((F+2)'(1) << F) - uraw : uraw;
          sneg <= qphase[31];
          m_a  <= 32'(qphase[30] ? (F+1)'((F+2)'(1) << F) - uraw : uraw);
          m_b  <= 32'(qphase[30] ? (F+1)'((F+2)'(1) << F) - uraw : uraw);
          m_start <= 1'b1; state <= S_U2;
        end
        S_U2: if (m_done) begin
          u2 <= (F+1)'(m_p >> F);
          m_a <= 32'(CC); m_b <= 32'(m_p >> F); m_start <= 1'b1; state <= S_T1;
        end
        S_T1: if (m_done) begin
          m_a <= 32'(u2); m_b <= 32'(t1w); m_start <= 1'b1; state <= S_T2;
        end
        S_T2: if (m_done) begin
          m_a <= 32'(u);
          m_b <= 32'((F+2)'(CA) - (F+2)'(m_p >> F));
          m_start <= 1'b1; state <= S_S;
        end
        S_S: if (m_done) begin
          m_a <= radius;
          m_b <= ((m_p >> F) > 64'((64'd1 << F) - 1)) ? 32'((64'd1 << F) - 1)
                                                       : 32'(m_p >> F);
          m_start <= 1'b1; state <= S_OFF;
        end
        S_OFF: if (m_done) begin
          if (!axis) begin
            offx <= sneg ? -34'sd0 - 34'(m_p >> F) : 34'(m_p >> F);
            axis <= 1'b1; state <= S_SEL;
          end else begin
            offz <= sneg ? -34'sd0 - 34'(m_p >> F) : 34'(m_p >> F);
            state <= S_POS;
          end
        end
        S_POS: begin
          px <= sat32(48'(item.center_x) + 48'(offx));
          pz <= sat32(48'(item.center_z) + 48'(offz));
          vidx <= 2'd0; state <= S_VEL;
        end
        S_VEL: begin
          unique case (vidx)
            2'd0:    res.vel_x <= prev_known ? sat32(vdiff) : '0;
            2'd1:    res.vel_y <= prev_known ? sat32(vdiff) : '0;
            default: res.vel_z <= prev_known ? sat32(vdiff) : '0;
          endcase
          vidx <= vidx + 2'd1;
          if (vidx == 2'd2) begin
            res.pos_x <= px; res.pos_y <= item.center_y; res.pos_z <= pz;
            res.spin_angle <= spin; res.spin_valid <= (srate != '0);
            prev_x <= px; prev_y <= item.center_y; prev_z <= pz;
            prev_known <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("accept while busy");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output dropped");
  a_known_after_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> prev_known) else $error("prev not latched");
`endif
endmodule
